>>> sv/cmcd_pkg.sv
// shared types, constants and helper functions for the color match cache
package cmcd_pkg;

  localparam int unsigned SET_COUNT_DEF     = 4096;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 3 * CHAN_W;
  localparam int unsigned TAG_W   = 18;
  localparam int unsigned KEY_W   = 12;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned ERR_W   = 9;

  typedef enum logic [1:0] {
    REQ_PAL_WRITE = 2'd0,
    REQ_LOOKUP    = 2'd1,
    REQ_FILL      = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_INDEX   = 2'd0,
    KIND_SEARCH  = 2'd1,
    KIND_REFUSED = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPARE,
    ST_ERR_HIT,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic             poison;
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] idx;
  } slot_t;

  typedef struct packed {
    slot_t s1;
    slot_t s0;
  } set_t;

  typedef struct packed {
    logic pal_wr;
    logic lookup_start;
    logic fill_start;
    logic clear_start;
    logic clear_step;
    logic emit_refuse;
    logic emit_hit;
    logic emit_miss;
    logic fill_write;
    logic pal_rd_hit;
    logic err_upd;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic dither;
    logic hit;
    logic clear_last;
  } status_t;

  function automatic logic [TAG_W-1:0] make_tag(logic [COLOR_W-1:0] c);
    return {c[23:18], c[15:10], c[7:2]};
  endfunction

  function automatic logic [KEY_W-1:0] set_key(logic [COLOR_W-1:0] c);
    return {c[21:18], c[13:10], c[5:2]};
  endfunction

  // add signed error to a channel and clamp to 0..255
  function automatic logic [CHAN_W-1:0] dither_chan(logic [CHAN_W-1:0] c,
                                                    logic signed [ERR_W-1:0] e);
    logic signed [ERR_W:0] s;
    s = $signed({2'b00, c}) + $signed({e[ERR_W-1], e});
    if (s[ERR_W]) begin
      return '0;
    end else if (s[ERR_W-1]) begin
      return '1;
    end else begin
      return s[CHAN_W-1:0];
    end
  endfunction

  // 3*(c - p)/4 truncated toward zero
  function automatic logic signed [ERR_W-1:0] err_of(logic [CHAN_W-1:0] c,
                                                     logic [CHAN_W-1:0] p);
    logic signed [ERR_W-1:0] d;
    logic signed [ERR_W+1:0] t;
    logic signed [ERR_W+1:0] q;
    d = $signed({1'b0, c}) - $signed({1'b0, p});
    t = $signed({d[ERR_W-1], d[ERR_W-1], d}) + $signed({d[ERR_W-1], d, 1'b0});
    if (t[ERR_W+1]) begin
      q = (t + 11'sd3) >>> 2;
    end else begin
      q = t >>> 2;
    end
    return q[ERR_W-1:0];
  endfunction

endpackage

>>> sv/cmcd_ctrl.sv
// sequencing state machine for the color match cache
module cmcd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       req_type_i,
  input  cmcd_pkg::status_t status_i,
  output cmcd_pkg::cmd_t   cmd_o,
  output logic             busy_o
);
  import cmcd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (req_e'(req_type_i))
            REQ_LOOKUP: begin
              if (!status_i.pending) state_d = ST_COMPARE;
            end
            REQ_FILL: begin
              if (status_i.pending) state_d = ST_FILL;
            end
            REQ_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_COMPARE: begin
        if (status_i.hit && status_i.dither) begin
          state_d = ST_ERR_HIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR_HIT: state_d = ST_IDLE;
      ST_FILL:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        if (start_i) begin
          case (req_e'(req_type_i))
            REQ_PAL_WRITE: cmd_o.pal_wr = 1'b1;
            REQ_LOOKUP: begin
              if (status_i.pending) begin
                cmd_o.emit_refuse = 1'b1;
              end else begin
                cmd_o.lookup_start = 1'b1;
              end
            end
            REQ_FILL:  cmd_o.fill_start = status_i.pending;
            REQ_CLEAR: cmd_o.clear_start = 1'b1;
            default:   cmd_o = '0;
          endcase
        end
      end
      ST_COMPARE: begin
        if (status_i.hit) begin
          cmd_o.emit_hit   = 1'b1;
          cmd_o.pal_rd_hit = status_i.dither;
        end else begin
          cmd_o.emit_miss = 1'b1;
        end
      end
      ST_ERR_HIT: cmd_o.err_upd = 1'b1;
      ST_FILL: begin
        cmd_o.fill_write = 1'b1;
        cmd_o.err_upd    = status_i.dither;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/cmcd_datapath.sv
// set memory, palette memory, error registers and result registers
module cmcd_datapath #(
  parameter int unsigned SET_COUNT     = cmcd_pkg::SET_COUNT_DEF,
  parameter int unsigned PALETTE_DEPTH = cmcd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmcd_pkg::cmd_t    cmd_i,
  output cmcd_pkg::status_t status_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        pal_index_i,
  output logic              result_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [7:0]        color_index_o,
  output logic              hit_o,
  output logic [7:0]        search_red_o,
  output logic [7:0]        search_green_o,
  output logic [7:0]        search_blue_o
);
  import cmcd_pkg::*;

  localparam int unsigned SET_AW = $clog2(SET_COUNT);
  localparam int unsigned PAL_AW = $clog2(PALETTE_DEPTH);

  set_t                 cache_mem [SET_COUNT];
  logic [COLOR_W-1:0]   pal_mem   [PALETTE_DEPTH];

  logic                    dither_q;
  logic                    pending_q;
  logic [COLOR_W-1:0]      pending_color_q;
  logic [SET_AW-1:0]       clr_cnt_q;
  logic signed [ERR_W-1:0] red_err_q, green_err_q, blue_err_q;
  logic [COLOR_W-1:0]      work_q;
  logic [IDX_W-1:0]        idx_q;
  set_t                    cache_rdata_q;
  logic [COLOR_W-1:0]      pal_rdata_q;
  logic                    pal_ok_q;

  logic                    valid_q;
  logic [1:0]              kind_q;
  logic [IDX_W-1:0]        cidx_q;
  logic                    hit_q;
  logic [COLOR_W-1:0]      search_q;

  logic [COLOR_W-1:0] in_color;
  logic [COLOR_W-1:0] dith_color;
  logic [COLOR_W-1:0] rd_color;
  logic [KEY_W-1:0]   rd_key;
  logic [KEY_W-1:0]   work_key;
  logic [TAG_W-1:0]   work_tag;
  logic               hit0, hit1;
  logic [IDX_W-1:0]   hit_idx;
  logic               cache_we;
  logic [SET_AW-1:0]  cache_waddr;
  set_t               cache_wdata;
  slot_t              new_slot;
  logic [IDX_W-1:0]   pal_raddr;
  logic               pal_rd;
  logic               pal_in_range;
  logic               pal_wr_in_range;
  logic [COLOR_W-1:0] pal_color;

  assign in_color   = {red_i, green_i, blue_i};
  assign dith_color = dither_q ? {dither_chan(red_i, red_err_q),
                                  dither_chan(green_i, green_err_q),
                                  dither_chan(blue_i, blue_err_q)} : in_color;

  assign rd_color = cmd_i.lookup_start ? dith_color : pending_color_q;
  assign rd_key   = set_key(rd_color);
  assign work_key = set_key(work_q);
  assign work_tag = make_tag(work_q);

  assign hit0    = !cache_rdata_q.s0.poison && (cache_rdata_q.s0.tag == work_tag);
  assign hit1    = !cache_rdata_q.s1.poison && (cache_rdata_q.s1.tag == work_tag);
  assign hit_idx = hit0 ? cache_rdata_q.s0.idx : cache_rdata_q.s1.idx;

  assign status_o.pending    = pending_q;
  assign status_o.dither     = dither_q;
  assign status_o.hit        = hit0 || hit1;
  assign status_o.clear_last = (clr_cnt_q == SET_AW'(SET_COUNT - 1));

  // set memory: clear sweep or fill write-back
  assign new_slot = '{poison: 1'b0, tag: work_tag, idx: idx_q};
  assign cache_we = cmd_i.clear_step || cmd_i.fill_write;

  always_comb begin
    if (cmd_i.clear_step) begin
      cache_waddr          = clr_cnt_q;
      cache_wdata          = '0;
      cache_wdata.s0.poison = (clr_cnt_q == '0);
      cache_wdata.s1.poison = (clr_cnt_q == '0);
    end else begin
      cache_waddr = work_key[SET_AW-1:0];
      cache_wdata = '{s1: cache_rdata_q.s0, s0: new_slot};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    if (cmd_i.lookup_start || cmd_i.fill_start) begin
      cache_rdata_q <= cache_mem[rd_key[SET_AW-1:0]];
    end
  end

  // palette memory
  assign pal_raddr       = cmd_i.fill_start ? pal_index_i : hit_idx;
  assign pal_rd          = cmd_i.fill_start || cmd_i.pal_rd_hit;
  assign pal_in_range    = ({1'b0, pal_raddr} < 9'(PALETTE_DEPTH));
  assign pal_wr_in_range = ({1'b0, pal_index_i} < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_wr && pal_wr_in_range) begin
      pal_mem[pal_index_i[PAL_AW-1:0]] <= in_color;
    end
    if (pal_rd) begin
      pal_ok_q <= pal_in_range;
      if (pal_in_range) pal_rdata_q <= pal_mem[pal_raddr[PAL_AW-1:0]];
    end
  end

  assign pal_color = pal_ok_q ? pal_rdata_q : '0;

  // working item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_start) work_q <= dith_color;
    else if (cmd_i.fill_start) work_q <= pending_color_q;
    if (cmd_i.fill_start) idx_q <= pal_index_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_q        <= 1'b0;
      pending_q       <= 1'b0;
      pending_color_q <= '0;
      clr_cnt_q       <= '0;
      red_err_q       <= '0;
      green_err_q     <= '0;
      blue_err_q      <= '0;
    end else begin
      if (cfg_we_i) dither_q <= cfg_wdata_i;
      if (cmd_i.clear_start) begin
        pending_q       <= 1'b0;
        pending_color_q <= '0;
        clr_cnt_q       <= '0;
        red_err_q       <= '0;
        green_err_q     <= '0;
        blue_err_q      <= '0;
      end else begin
        if (cmd_i.clear_step) begin
          clr_cnt_q <= status_o.clear_last ? '0 : clr_cnt_q + 1'b1;
        end
        if (cmd_i.emit_miss) begin
          pending_q       <= 1'b1;
          pending_color_q <= work_q;
        end else if (cmd_i.fill_write) begin
          pending_q       <= 1'b0;
          pending_color_q <= '0;
        end
        if (cmd_i.err_upd) begin
          red_err_q   <= err_of(work_q[23:16], pal_color[23:16]);
          green_err_q <= err_of(work_q[15:8], pal_color[15:8]);
          blue_err_q  <= err_of(work_q[7:0], pal_color[7:0]);
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_refuse || cmd_i.emit_hit || cmd_i.emit_miss || cmd_i.fill_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_refuse) begin
      kind_q   <= KIND_REFUSED;
      cidx_q   <= '0;
      hit_q    <= 1'b0;
      search_q <= '0;
    end else if (cmd_i.emit_hit) begin
      kind_q   <= KIND_INDEX;
      cidx_q   <= hit_idx;
      hit_q    <= 1'b1;
      search_q <= '0;
    end else if (cmd_i.emit_miss) begin
      kind_q   <= KIND_SEARCH;
      cidx_q   <= '0;
      hit_q    <= 1'b0;
      search_q <= work_q;
    end else if (cmd_i.fill_write) begin
      kind_q   <= KIND_INDEX;
      cidx_q   <= idx_q;
      hit_q    <= 1'b0;
      search_q <= '0;
    end
  end

  assign result_valid_o = valid_q;
  assign result_kind_o  = kind_q;
  assign color_index_o  = cidx_q;
  assign hit_o          = hit_q;
  assign search_red_o   = search_q[23:16];
  assign search_green_o = search_q[15:8];
  assign search_blue_o  = search_q[7:0];

endmodule

>>> sv/color_match_cache_dither_core.sv
// top level of the two-way color match cache with error diffusion
// lookup and fill: one set memory read then a compare or write-back state, which
//   registers the result; a dithered hit adds an error update state; a new item
//   is not taken until busy drops; a refused lookup is registered straight from idle
// palette write stays in idle; clear: one set memory row swept per busy cycle;
//   reset runs the same sweep; results cannot be stalled
module color_match_cache_dither_core #(
  parameter int unsigned SET_COUNT     = cmcd_pkg::SET_COUNT_DEF,
  parameter int unsigned PALETTE_DEPTH = cmcd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] pal_index_i,
  output logic       result_valid_o,
  output logic [1:0] result_kind_o,
  output logic [7:0] color_index_o,
  output logic       hit_o,
  output logic [7:0] search_red_o,
  output logic [7:0] search_green_o,
  output logic [7:0] search_blue_o
);
  import cmcd_pkg::*;

  cmd_t    cmd;
  status_t status;

  cmcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  cmcd_datapath #(
    .SET_COUNT     (SET_COUNT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .pal_index_i    (pal_index_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .color_index_o  (color_index_o),
    .hit_o          (hit_o),
    .search_red_o   (search_red_o),
    .search_green_o (search_green_o),
    .search_blue_o  (search_blue_o)
  );

endmodule
